// File: hdl/q2e_pkg.sv
// Shared types, constants and helper functions for the quaternion to Euler angle block.
// Used by every module under hdl; depends on nothing else.
package q2e_pkg;

    localparam int QW          = 16;
    localparam int WW          = 35;
    localparam int PW          = 64;
    localparam int RW          = 32;
    localparam int REMW        = 34;
    localparam int XYW         = 45;
    localparam int ACCW        = 25;
    localparam int SQRT_STEPS  = 32;
    localparam int CORDIC_STEPS = 23;
    localparam int PRESCALE_BIT = 40;
    localparam int ANG_DROP    = 9;

    localparam logic signed [ACCW-1:0] ANG_90    = 25'sd5898240;
    localparam logic signed [ACCW-1:0] ANG_180   = 25'sd11796480;
    localparam logic signed [ACCW-1:0] ANG_ROUND = 25'sd256;

    typedef struct packed {
        logic ax_zero;
        logic ay_zero;
        logic x_neg;
        logic y_neg;
    } t_qflags;

    typedef struct packed {
        logic signed [WW-1:0] roll_y;
        logic signed [WW-1:0] roll_x;
        logic signed [WW-1:0] yaw_y;
        logic signed [WW-1:0] yaw_x;
        logic signed [WW-1:0] s;
        logic                 n_zero;
    } t_args;

    // Index of the highest set bit; zero for a zero word.
    function automatic logic [5:0] msb_index(input logic [WW-1:0] v);
        logic [5:0] idx;
        idx = '0;
        for (int b = 0; b < WW; b++) begin
            if (v[b]) begin
                idx = 6'(b);
            end
        end
        return idx;
    endfunction

    // atan(2^-i) in units of 2^-16 degree.
    function automatic logic signed [ACCW-1:0] atan_of(input logic [4:0] i);
        logic signed [ACCW-1:0] a;
        case (i)
            5'd0:  a = 25'sd2949120;
            5'd1:  a = 25'sd1740967;
            5'd2:  a = 25'sd919879;
            5'd3:  a = 25'sd466945;
            5'd4:  a = 25'sd234379;
            5'd5:  a = 25'sd117304;
            5'd6:  a = 25'sd58666;
            5'd7:  a = 25'sd29335;
            5'd8:  a = 25'sd14668;
            5'd9:  a = 25'sd7334;
            5'd10: a = 25'sd3667;
            5'd11: a = 25'sd1833;
            5'd12: a = 25'sd917;
            5'd13: a = 25'sd458;
            5'd14: a = 25'sd229;
            5'd15: a = 25'sd115;
            5'd16: a = 25'sd57;
            5'd17: a = 25'sd29;
            5'd18: a = 25'sd14;
            5'd19: a = 25'sd7;
            5'd20: a = 25'sd4;
            5'd21: a = 25'sd2;
            5'd22: a = 25'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// File: hdl/quaternion_to_euler_angles.sv
// Top level of the quaternion to roll, pitch and yaw converter.
// Depends on q2e_pkg, q2e_sqrt_cell and q2e_angle.
//
// Takes one Q1.14 quaternion per cycle and returns roll, pitch and yaw in 1/128 degree.
// Registers for products, sums and operand scaling feed 32 square-root cells, and each
// atan2 lane has quadrant reduction, prescaling, 23 CORDIC cells and an output register.
// Items are independent and the whole pipeline advances whenever the output register
// is empty or being read, so the sustained rate is one item per cycle.
module quaternion_to_euler_angles
    import q2e_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata   // roll_deg, pitch_deg, yaw_deg, one zero pad bit
);

    localparam int LAT = 5 + SQRT_STEPS + CORDIC_STEPS + 3;

    logic w_en;
    logic [LAT-1:0] r_vld;

    logic signed [QW-1:0] w_w, w_x, w_y, w_z;
    logic signed [31:0] r_ww, r_xx, r_yy, r_zz, r_wx, r_yz, r_wz, r_xy, r_wy, r_zx;
    logic signed [WW-1:0] r_n;
    t_args n_args2, r_args2, r_args3, r_args4, r_args5;
    t_args n_args3, n_args4;

    logic signed [WW:0] w_u, w_v;
    logic [WW-1:0] w_uu, w_vv, w_m;
    logic [WW-1:0] r_uu, r_vv;
    logic          r_big;
    logic [5:0]    r_k;
    logic [31:0]   r_su, r_sv;
    logic [PW-1:0] r_p;
    logic signed [WW-1:0] w_s4;

    logic [PW-1:0]   w_p    [0:SQRT_STEPS];
    logic [REMW-1:0] w_rem  [0:SQRT_STEPS];
    logic [RW-1:0]   w_root [0:SQRT_STEPS];
    t_args           r_dly  [0:SQRT_STEPS-1];

    t_args                w_a;
    logic signed [WW-1:0] w_pitch_x;
    logic signed [15:0]   w_roll, w_pitch, w_yaw;

    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    assign w_w = i_s_tdata[15:0];
    assign w_x = i_s_tdata[31:16];
    assign w_y = i_s_tdata[47:32];
    assign w_z = i_s_tdata[63:48];

    always_comb begin
        n_args2.roll_y = (WW'(r_wx) + WW'(r_yz)) <<< 1;
        n_args2.roll_x = WW'(r_ww) - WW'(r_xx) - WW'(r_yy) + WW'(r_zz);
        n_args2.yaw_y  = (WW'(r_wz) + WW'(r_xy)) <<< 1;
        n_args2.yaw_x  = WW'(r_ww) + WW'(r_xx) - WW'(r_yy) - WW'(r_zz);
        n_args2.s      = (WW'(r_wy) - WW'(r_zx)) <<< 1;
        n_args2.n_zero = 1'b0;
    end

    always_comb begin
        w_u  = (WW+1)'(r_n) - (WW+1)'(r_args2.s);
        w_v  = (WW+1)'(r_n) + (WW+1)'(r_args2.s);
        w_uu = w_u[WW] ? '0 : w_u[WW-1:0];
        w_vv = w_v[WW] ? '0 : w_v[WW-1:0];
        w_m  = (w_uu > w_vv) ? w_uu : w_vv;
    end

    always_comb begin
        n_args3        = r_args2;
        n_args3.n_zero = (r_n == '0);
    end

    always_comb begin
        if (r_big) begin
            w_s4 = (r_args3.s + $signed({{(WW-1){1'b0}}, r_args3.s[WW-1]})) >>> 1;
        end else begin
            w_s4 = r_args3.s <<< r_k;
        end
    end

    always_comb begin
        n_args4   = r_args3;
        n_args4.s = w_s4;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ww <= w_w * w_w;
            r_xx <= w_x * w_x;
            r_yy <= w_y * w_y;
            r_zz <= w_z * w_z;
            r_wx <= w_w * w_x;
            r_yz <= w_y * w_z;
            r_wz <= w_w * w_z;
            r_xy <= w_x * w_y;
            r_wy <= w_w * w_y;
            r_zx <= w_z * w_x;

            r_n     <= WW'(r_ww) + WW'(r_xx) + WW'(r_yy) + WW'(r_zz);
            r_args2 <= n_args2;

            r_uu    <= w_uu;
            r_vv    <= w_vv;
            r_big   <= (w_m[WW-1:32] != '0);
            r_k     <= 6'd31 - msb_index(w_m);
            r_args3 <= n_args3;

            r_su    <= r_big ? 32'(r_uu >> 1) : 32'(r_uu << r_k);
            r_sv    <= r_big ? 32'(r_vv >> 1) : 32'(r_vv << r_k);
            r_args4 <= n_args4;

            r_p     <= PW'(r_su) * PW'(r_sv);
            r_args5 <= r_args4;

            r_dly[0] <= r_args5;
            for (int d = 1; d < SQRT_STEPS; d++) begin
                r_dly[d] <= r_dly[d-1];
            end
        end
    end

    assign w_p[0]    = r_p;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        q2e_sqrt_cell u_sqrt (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_p    (w_p[g]),
            .i_rem  (w_rem[g]),
            .i_root (w_root[g]),
            .o_p    (w_p[g+1]),
            .o_rem  (w_rem[g+1]),
            .o_root (w_root[g+1])
        );
    end

    assign w_a       = r_dly[SQRT_STEPS-1];
    assign w_pitch_x = w_a.n_zero ? '0 : $signed(WW'(w_root[SQRT_STEPS]));

    q2e_angle u_roll (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (w_a.roll_y),
        .i_x     (w_a.roll_x),
        .o_angle (w_roll)
    );

    q2e_angle u_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (w_a.s),
        .i_x     (w_pitch_x),
        .o_angle (w_pitch)
    );

    q2e_angle u_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (w_a.yaw_y),
        .i_x     (w_a.yaw_x),
        .o_angle (w_yaw)
    );

    assign o_m_tdata = {1'b0, w_yaw, w_pitch[14:0], w_roll};

endmodule

// File: hdl/q2e_sqrt_cell.sv
// One bit of the pipelined integer square root: decides one root bit per cycle while i_en is high.
// Depends on q2e_pkg.
module q2e_sqrt_cell
    import q2e_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [PW-1:0]   i_p,
    input  logic [REMW-1:0] i_rem,
    input  logic [RW-1:0]   i_root,
    output logic [PW-1:0]   o_p,
    output logic [REMW-1:0] o_rem,
    output logic [RW-1:0]   o_root
);

    logic [REMW+1:0] w_rem2;
    logic [REMW+1:0] w_trial;
    logic [PW-1:0]   n_p;
    logic [REMW-1:0] n_rem;
    logic [RW-1:0]   n_root;
    logic [PW-1:0]   r_p;
    logic [REMW-1:0] r_rem;
    logic [RW-1:0]   r_root;

    always_comb begin
        w_rem2  = {i_rem, i_p[PW-1:PW-2]};
        w_trial = {2'b00, i_root, 2'b01};
        n_p     = {i_p[PW-3:0], 2'b00};
        if (w_rem2 >= w_trial) begin
            n_rem  = REMW'(w_rem2 - w_trial);
            n_root = {i_root[RW-2:0], 1'b1};
        end else begin
            n_rem  = REMW'(w_rem2);
            n_root = {i_root[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= n_p;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_p    = r_p;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// File: hdl/q2e_cordic_cell.sv
// One vectoring CORDIC rotation with a registered output.
// Depends on q2e_pkg.
module q2e_cordic_cell
    import q2e_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [4:0]             i_step,
    input  logic signed [XYW-1:0]  i_px,
    input  logic signed [XYW-1:0]  i_py,
    input  logic signed [ACCW-1:0] i_acc,
    input  t_qflags                i_flags,
    output logic signed [XYW-1:0]  o_px,
    output logic signed [XYW-1:0]  o_py,
    output logic signed [ACCW-1:0] o_acc,
    output t_qflags                o_flags
);

    logic signed [XYW-1:0]  w_dx;
    logic signed [XYW-1:0]  w_dy;
    logic signed [XYW-1:0]  n_px;
    logic signed [XYW-1:0]  n_py;
    logic signed [ACCW-1:0] n_acc;
    logic signed [XYW-1:0]  r_px;
    logic signed [XYW-1:0]  r_py;
    logic signed [ACCW-1:0] r_acc;
    t_qflags                r_flags;

    always_comb begin
        w_dx = i_py >>> i_step;
        w_dy = i_px >>> i_step;
        if (i_py >= 0) begin
            n_px  = i_px + w_dx;
            n_py  = i_py - w_dy;
            n_acc = i_acc + atan_of(i_step);
        end else begin
            n_px  = i_px - w_dx;
            n_py  = i_py + w_dy;
            n_acc = i_acc - atan_of(i_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px    <= n_px;
            r_py    <= n_py;
            r_acc   <= n_acc;
            r_flags <= i_flags;
        end
    end

    assign o_px    = r_px;
    assign o_py    = r_py;
    assign o_acc   = r_acc;
    assign o_flags = r_flags;

endmodule

// File: hdl/q2e_angle.sv
// One atan2 lane: quadrant reduction, prescaling, a row of CORDIC cells and rounding.
// Depends on q2e_pkg and q2e_cordic_cell.
module q2e_angle
    import q2e_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [WW-1:0] i_y,
    input  logic signed [WW-1:0] i_x,
    output logic signed [15:0]   o_angle
);

    logic [WW-1:0]          n_ax;
    logic [WW-1:0]          n_ay;
    logic [5:0]             n_k;
    t_qflags                n_flags;
    logic [WW-1:0]          r_ax;
    logic [WW-1:0]          r_ay;
    logic [5:0]             r_k;
    t_qflags                r_flags1;
    logic signed [XYW-1:0]  r_px;
    logic signed [XYW-1:0]  r_py;
    t_qflags                r_flags2;
    logic [5:0]             w_msb;

    logic signed [XYW-1:0]  w_px    [0:CORDIC_STEPS];
    logic signed [XYW-1:0]  w_py    [0:CORDIC_STEPS];
    logic signed [ACCW-1:0] w_acc   [0:CORDIC_STEPS];
    t_qflags                w_flags [0:CORDIC_STEPS];

    logic signed [ACCW-1:0] w_th;
    logic signed [ACCW-1:0] w_rnd;
    logic signed [15:0]     n_angle;
    logic signed [15:0]     r_angle;

    always_comb begin
        n_ax = i_x[WW-1] ? WW'(-i_x) : WW'(i_x);
        n_ay = i_y[WW-1] ? WW'(-i_y) : WW'(i_y);
        n_flags.ax_zero = (i_x == '0);
        n_flags.ay_zero = (i_y == '0);
        n_flags.x_neg   = i_x[WW-1];
        n_flags.y_neg   = i_y[WW-1];
        w_msb = msb_index(n_ax | n_ay);
        n_k   = 6'(PRESCALE_BIT) - w_msb;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax     <= n_ax;
            r_ay     <= n_ay;
            r_k      <= n_k;
            r_flags1 <= n_flags;
            r_px     <= $signed(XYW'(r_ax) << r_k);
            r_py     <= $signed(XYW'(r_ay) << r_k);
            r_flags2 <= r_flags1;
        end
    end

    assign w_px[0]    = r_px;
    assign w_py[0]    = r_py;
    assign w_acc[0]   = '0;
    assign w_flags[0] = r_flags2;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        q2e_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (i_en),
            .i_step  (5'(g)),
            .i_px    (w_px[g]),
            .i_py    (w_py[g]),
            .i_acc   (w_acc[g]),
            .i_flags (w_flags[g]),
            .o_px    (w_px[g+1]),
            .o_py    (w_py[g+1]),
            .o_acc   (w_acc[g+1]),
            .o_flags (w_flags[g+1])
        );
    end

    always_comb begin
        w_th = w_acc[CORDIC_STEPS];
        if (w_th < 0) begin
            w_th = '0;
        end
        if (w_th > ANG_90) begin
            w_th = ANG_90;
        end
        if (w_flags[CORDIC_STEPS].ay_zero) begin
            w_th = '0;
        end else if (w_flags[CORDIC_STEPS].ax_zero) begin
            w_th = ANG_90;
        end
        if (w_flags[CORDIC_STEPS].x_neg) begin
            w_th = ANG_180 - w_th;
        end
        w_rnd   = (w_th + ANG_ROUND) >>> ANG_DROP;
        n_angle = w_flags[CORDIC_STEPS].y_neg ? 16'(-w_rnd) : 16'(w_rnd);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

// File: verif/quaternion_to_euler_angles_test.sv
// Testbench for quaternion_to_euler_angles: drives quaternions over the input stream and
// checks roll, pitch and yaw on the output stream against a predictor of its own.
// Depends on the RTL under hdl only.
`timescale 1ns / 100ps

module quaternion_to_euler_angles_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_ITEMS   = 1000;

    localparam longint A90   = 64'sd5898240;
    localparam longint A180  = 64'sd11796480;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic signed [15:0] w;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
    } t_angles;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;

    t_quat   pending_quats[$];
    t_angles expected_angles[$];
    int      error_count;
    int      idle_cycles;
    bit      stimulus_done;
    bit      hold_sender;
    bit      s_accepted;
    int      burst_left;
    int      gap_left;
    int      stall_phase;

    quaternion_to_euler_angles u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint first_quadrant_angle(longint ax, longint ay);
        longint px;
        longint py;
        longint acc;
        longint dx;
        longint dy;
        longint tab[23];
        tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
        acc = 0;
        while (((ax | ay) >>> 40) == 0) begin
            ax = ax <<< 1;
            ay = ay <<< 1;
        end
        px = ax;
        py = ay;
        for (int i = 0; i < 23; i++) begin
            dx = floor_shr(py, i);
            dy = floor_shr(px, i);
            if (py >= 0) begin
                px += dx;
                py -= dy;
                acc += tab[i];
            end else begin
                px -= dx;
                py += dy;
                acc -= tab[i];
            end
        end
        if (acc < 0) acc = 0;
        if (acc > A90) acc = A90;
        return acc;
    endfunction

    function automatic longint atan2_deg128(longint y, longint x);
        longint ax;
        longint ay;
        longint th;
        longint r;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        if (ay == 0) th = 0;
        else if (ax == 0) th = A90;
        else th = first_quadrant_angle(ax, ay);
        if (x < 0) th = A180 - th;
        r = (th + 256) >>> 9;
        return (y < 0) ? -r : r;
    endfunction

    function automatic longint floor_sqrt(longint unsigned p);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > p) b = b >> 2;
        while (b != 0) begin
            if (p >= r + b) begin
                p = p - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic t_angles euler_of(t_quat q);
        t_angles a;
        longint w;
        longint x;
        longint y;
        longint z;
        longint n;
        longint s;
        longint u;
        longint v;
        longint m;
        longint unsigned lim;
        w = q.w;
        x = q.x;
        y = q.y;
        z = q.z;
        n = w * w + x * x + y * y + z * z;
        a = '0;
        lim = 64'd1 << 32;
        if (n != 0) begin
            a.roll = 16'(atan2_deg128(2 * (w * x + y * z), w * w - x * x - y * y + z * z));
            a.yaw = 16'(atan2_deg128(2 * (w * z + x * y), w * w + x * x - y * y - z * z));
            s = 2 * (w * y - z * x);
            u = n - s;
            v = n + s;
            if (u < 0) u = 0;
            if (v < 0) v = 0;
            m = (u > v) ? u : v;
            if (longint'(m) >= longint'(lim)) begin
                u = u >> 1;
                v = v >> 1;
                s = s / 2;
            end else begin
                while ((m << 1) < longint'(lim)) begin
                    m = m << 1;
                    u = u << 1;
                    v = v << 1;
                    s = s * 2;
                end
            end
            a.pitch = 15'(atan2_deg128(s, floor_sqrt(longint'(u) * longint'(v))));
        end
        return a;
    endfunction

    function automatic t_quat rand_quat(int mode);
        t_quat q;
        q.w = 16'($urandom);
        q.x = 16'($urandom);
        q.y = 16'($urandom);
        q.z = 16'($urandom);
        case (mode)
            0: begin
                q.w = 16'($urandom_range(0, 2048)) - 16'sd1024;
                q.x = 16'($urandom_range(0, 2048)) - 16'sd1024;
            end
            1: begin
                q.x = q.w;
                q.z = q.y;
            end
            2: begin
                q.z = -q.x;
                q.y = q.w;
            end
            3: begin
                q.y = 16'sd0;
                q.x = 16'($urandom_range(0, 8)) - 16'sd4;
            end
            default: ;
        endcase
        return q;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    initial begin
        t_quat q;
        int unsigned edges[6];
        edges = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h4000};
        q = '0;
        pending_quats.push_back(q);
        pending_quats.push_back('{w: 16'sd16384, x: 16'sd0, y: 16'sd0, z: 16'sd0});
        pending_quats.push_back('{w: 16'sd11585, x: 16'sd0, y: 16'sd11585, z: 16'sd0});
        pending_quats.push_back('{w: 16'sd11585, x: 16'sd0, y: -16'sd11585, z: 16'sd0});
        pending_quats.push_back('{w: 16'sd0, x: 16'sd16384, y: 16'sd0, z: 16'sd0});
        pending_quats.push_back('{w: 16'sd0, x: 16'sd0, y: 16'sd0, z: 16'sd16384});
        pending_quats.push_back('{w: 16'sd0, x: 16'sd0, y: 16'sd16384, z: 16'sd0});
        pending_quats.push_back('{w: 16'sd1, x: 16'sd1, y: 16'sd1, z: 16'sd1});
        pending_quats.push_back('{w: -16'sd32768, x: -16'sd32768, y: -16'sd32768,
                                  z: -16'sd32768});
        pending_quats.push_back('{w: 16'sd32767, x: 16'sd32767, y: 16'sd32767,
                                  z: 16'sd32767});
        pending_quats.push_back('{w: 16'sd32767, x: -16'sd32768, y: 16'sd32767,
                                  z: -16'sd32768});
        pending_quats.push_back('{w: 16'sd0, x: 16'sd1, y: 16'sd0, z: 16'sd0});
        for (int k = 0; k < 12; k++) begin
            q.w = 16'(edges[$urandom_range(0, 5)]);
            q.x = 16'(edges[$urandom_range(0, 5)]);
            q.y = 16'(edges[$urandom_range(0, 5)]);
            q.z = 16'(edges[$urandom_range(0, 5)]);
            pending_quats.push_back(q);
        end
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            pending_quats.push_back(rand_quat($urandom_range(0, 7)));
        end
    end

    // Sender: bursts with gaps, and one hold until the output side has drained.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata <= '0;
        end else if (!i_s_tvalid || s_accepted) begin
            if (hold_sender && expected_angles.size() != 0 && pending_quats.size() < 500) begin
                i_s_tvalid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_s_tvalid <= 1'b0;
            end else if (pending_quats.size() != 0) begin
                hold_sender <= (pending_quats.size() == 500) ? 1'b1
                             : (expected_angles.size() == 0 ? 1'b0 : hold_sender);
                i_s_tvalid <= 1'b1;
                i_s_tdata <= pending_quats.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_s_tvalid <= 1'b0;
                stimulus_done <= 1'b1;
            end
        end
    end

    // Receiver stall pattern drifts between free flow and heavy back-pressure.
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (stall_phase[8]) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 3) != 0) && !(stall_phase[3:0] == 4'd7);
        end
    end

    always @(posedge i_clk) begin
        t_angles got;
        t_angles want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                expected_angles.push_back(euler_of(t_quat'(i_s_tdata)));
            end
            if (o_m_tvalid && i_m_tready) begin
                got = t_angles'(o_m_tdata[46:0]);
                if (expected_angles.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    want = expected_angles.pop_front();
                    if (got.roll != want.roll) report_mismatch("roll", got.roll, want.roll);
                    if (got.pitch != want.pitch) begin
                        report_mismatch("pitch", got.pitch, want.pitch);
                    end
                    if (got.yaw != want.yaw) report_mismatch("yaw", got.yaw, want.yaw);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        s_accepted <= i_s_tvalid && o_s_tready;
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        error_count = 0;
        idle_cycles = 0;
        stimulus_done = 1'b0;
        hold_sender = 1'b0;
        s_accepted = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (!(stimulus_done && expected_angles.size() == 0)
               && idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            #1;
            if (error_count == 0) begin
                $display("SUCCESS");
            end else begin
                $display("FAILURE");
            end
        end
        $finish;
    end

endmodule
